>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/core/eitp_pkg.sv
// Types, constants and helpers of the Ethernet/IPv4/TCP header parser.
package eitp_pkg;

  localparam logic [15:0] HTTP_PORT_RST  = 16'h0050;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  CH_CR          = 8'h0d;
  localparam logic [7:0]  CH_LF          = 8'h0a;
  localparam logic [7:0]  CH_DOT         = 8'h2e;
  localparam logic [7:0]  CH_PRINT_LO    = 8'h20;
  localparam logic [7:0]  CH_PRINT_HI    = 8'h7e;
  localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;

  localparam int unsigned OFIFO_DEPTH = 4;
  localparam int unsigned OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int unsigned OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_ETH   = 3'd0,
    KIND_IPV4  = 3'd1,
    KIND_TCP   = 3'd2,
    KIND_CHAR  = 3'd3,
    KIND_BREAK = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       start_of_frame;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [5:0]  ip_header_len;
    logic [15:0] src_tcp_port;
    logic [15:0] dst_port;
    logic [5:0]  tcp_header_len;
    logic [15:0] payload_len;
    logic [7:0]  payload_char;
    logic        last;
  } out_t;

  // Up to two results per frame byte, in order res0 then res1.
  typedef struct packed {
    logic [1:0] cnt;
    out_t       res0;
    out_t       res1;
  } push_t;

  function automatic out_t make_text(kind_e k, logic [7:0] ch, logic last);
    out_t r;
    r              = '0;
    r.kind         = k;
    r.payload_char = ch;
    r.last         = last;
    return r;
  endfunction

endpackage

>>> rtl/core/eitp_parser.sv
// Per-byte header capture, phase control and payload text mapping.
module eitp_parser
  import eitp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_fire_i,
  input  in_t         in_data_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output push_t       push_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ETH,
    PH_IP,
    PH_TCP,
    PH_PAY,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] http_port_q, http_port_d;
  logic        pcr_q, pcr_d;
  logic [5:0]  off_q, off_d;
  logic [47:0] dst_mac_q, dst_mac_d, src_mac_q, src_mac_d;
  logic [15:0] etype_q, etype_d;
  logic [31:0] src_ip_q, src_ip_d, dst_ip_q, dst_ip_d;
  logic [15:0] iplen_q, iplen_d;
  logic [5:0]  ihl_q, ihl_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] sport_q, sport_d, dport_q, dport_d;
  logic [5:0]  thl_q, thl_d;
  logic [15:0] left_q, left_d;

  logic [7:0]  b;
  logic [5:0]  off;
  logic [6:0]  off_inc;
  logic [6:0]  hdrs;
  logic [15:0] plen;
  logic        fin;
  logic        lf_done;
  logic        dot_first;
  logic [7:0]  ch;
  out_t        rec;

  always_comb begin
    phase_d     = phase_q;
    http_port_d = cfg_we_i ? cfg_wdata_i : http_port_q;
    pcr_d       = pcr_q;
    off_d       = off_q;
    dst_mac_d   = dst_mac_q;
    src_mac_d   = src_mac_q;
    etype_d     = etype_q;
    src_ip_d    = src_ip_q;
    dst_ip_d    = dst_ip_q;
    iplen_d     = iplen_q;
    ihl_d       = ihl_q;
    proto_d     = proto_q;
    sport_d     = sport_q;
    dport_d     = dport_q;
    thl_d       = thl_q;
    left_d      = left_q;
    push_o      = '0;
    b           = in_data_i.frame_byte;
    off         = off_q;
    off_inc     = 7'd0;
    hdrs        = 7'd0;
    plen        = 16'd0;
    fin         = 1'b0;
    lf_done     = 1'b0;
    dot_first   = 1'b0;
    ch          = CH_DOT;
    rec         = '0;

    if (in_fire_i) begin
      // Restart on a new frame: clear all captures first.
      if (in_data_i.start_of_frame) begin
        phase_d   = PH_ETH;
        off_d     = '0;
        dst_mac_d = '0;
        src_mac_d = '0;
        etype_d   = '0;
        src_ip_d  = '0;
        dst_ip_d  = '0;
        iplen_d   = '0;
        ihl_d     = '0;
        proto_d   = '0;
        sport_d   = '0;
        dport_d   = '0;
        thl_d     = '0;
        left_d    = '0;
        pcr_d     = 1'b0;
      end
      off     = off_d;
      off_inc = {1'b0, off} + 7'd1;

      // Per-phase byte handling; records use the captures as they stand after this byte.
      unique case (phase_d)
        PH_ETH: begin
          if (off < 6'd6) begin
            dst_mac_d = {dst_mac_d[39:0], b};
          end else if (off < 6'd12) begin
            src_mac_d = {src_mac_d[39:0], b};
          end else begin
            etype_d = {etype_d[7:0], b};
          end
          if (off >= 6'd13) begin
            off_d = '0;
            if (etype_d == ETHERTYPE_IPV4) begin
              phase_d = PH_IP;
            end else begin
              phase_d          = PH_DONE;
              rec.kind         = KIND_ETH;
              rec.src_mac      = src_mac_d;
              rec.dst_mac      = dst_mac_d;
              rec.last         = 1'b1;
              push_o.cnt       = 2'd1;
              push_o.res0      = rec;
            end
          end else begin
            off_d = off_inc[5:0];
          end
        end

        PH_IP: begin
          if (off == 6'd0) begin
            ihl_d = {b[3:0], 2'b00};
          end else if (off == 6'd2 || off == 6'd3) begin
            iplen_d = {iplen_d[7:0], b};
          end else if (off == 6'd9) begin
            proto_d = b;
          end else if (off >= 6'd12 && off < 6'd16) begin
            src_ip_d = {src_ip_d[23:0], b};
          end else if (off >= 6'd16 && off < 6'd20) begin
            dst_ip_d = {dst_ip_d[23:0], b};
          end
          if (off == 6'd19 && (ihl_d < MIN_HDR_BYTES || proto_d != PROTO_TCP)) begin
            phase_d           = PH_DONE;
            rec.kind          = KIND_IPV4;
            rec.src_mac       = src_mac_d;
            rec.dst_mac       = dst_mac_d;
            rec.src_ip        = src_ip_d;
            rec.dst_ip        = dst_ip_d;
            rec.ip_header_len = ihl_d;
            rec.last          = 1'b1;
            push_o.cnt        = 2'd1;
            push_o.res0       = rec;
          end else if (off >= 6'd19 && off_inc >= {1'b0, ihl_d}) begin
            // Options skipped; TCP header starts with the next byte.
            phase_d = PH_TCP;
            off_d   = '0;
          end else begin
            off_d = off_inc[5:0];
          end
        end

        PH_TCP: begin
          if (off < 6'd2) begin
            sport_d = {sport_d[7:0], b};
          end else if (off < 6'd4) begin
            dport_d = {dport_d[7:0], b};
          end else if (off == 6'd12) begin
            thl_d = {b[7:4], 2'b00};
          end
          if (off == 6'd19) begin
            hdrs = {1'b0, ihl_d} + {1'b0, thl_d};
            if (thl_d >= MIN_HDR_BYTES &&
                (sport_d == http_port_q || dport_d == http_port_q) &&
                iplen_d > {9'd0, hdrs}) begin
              plen = iplen_d - {9'd0, hdrs};
            end
            rec.kind           = KIND_TCP;
            rec.src_mac        = src_mac_d;
            rec.dst_mac        = dst_mac_d;
            rec.src_ip         = src_ip_d;
            rec.dst_ip         = dst_ip_d;
            rec.ip_header_len  = ihl_d;
            rec.src_tcp_port   = sport_d;
            rec.dst_port       = dport_d;
            rec.tcp_header_len = thl_d;
            rec.payload_len    = plen;
            rec.last           = (plen == 16'd0);
            push_o.cnt         = 2'd1;
            push_o.res0        = rec;
            if (plen == 16'd0) begin
              phase_d = PH_DONE;
            end else begin
              left_d = plen;
              if (thl_d == MIN_HDR_BYTES) begin
                phase_d = PH_PAY;
                off_d   = '0;
              end else begin
                off_d = off_inc[5:0];
              end
            end
          end else if (off > 6'd19 && off_inc >= {1'b0, thl_d}) begin
            phase_d = PH_PAY;
            off_d   = '0;
          end else begin
            off_d = off_inc[5:0];
          end
        end

        PH_PAY: begin
          left_d = left_d - 16'd1;
          fin    = (left_d == 16'd0);
          if (fin) begin
            phase_d = PH_DONE;
          end
          // Held CR: merge with LF into a line break, else emit it as a dot.
          if (pcr_d) begin
            pcr_d = 1'b0;
            if (b == CH_LF) begin
              lf_done     = 1'b1;
              push_o.cnt  = 2'd1;
              push_o.res0 = make_text(KIND_BREAK, 8'd0, fin);
            end else begin
              dot_first   = 1'b1;
              push_o.res0 = make_text(KIND_CHAR, CH_DOT, 1'b0);
            end
          end
          if (!lf_done) begin
            if (b == CH_CR && !fin) begin
              pcr_d      = 1'b1;
              push_o.cnt = dot_first ? 2'd1 : 2'd0;
            end else begin
              if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
                ch = b;
              end
              if (dot_first) begin
                push_o.cnt  = 2'd2;
                push_o.res1 = make_text(KIND_CHAR, ch, fin);
              end else begin
                push_o.cnt  = 2'd1;
                push_o.res0 = make_text(KIND_CHAR, ch, fin);
              end
            end
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      http_port_q <= HTTP_PORT_RST;
      pcr_q       <= 1'b0;
      off_q       <= '0;
      left_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      http_port_q <= http_port_d;
      pcr_q       <= pcr_d;
      off_q       <= off_d;
      left_q      <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_mac_q <= dst_mac_d;
    src_mac_q <= src_mac_d;
    etype_q   <= etype_d;
    src_ip_q  <= src_ip_d;
    dst_ip_q  <= dst_ip_d;
    iplen_q   <= iplen_d;
    ihl_q     <= ihl_d;
    proto_q   <= proto_d;
    sport_q   <= sport_d;
    dport_q   <= dport_d;
    thl_q     <= thl_d;
  end

endmodule

>>> rtl/core/eitp_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
module eitp_out_fifo
  import eitp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  out_t                   mem_q [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OFIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OFIFO_CNT_W-1:0] count_q, count_d;
  logic [OFIFO_PTR_W-1:0] wr_ptr_nxt;
  logic                   pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;
  // Keep room for the two results one byte can raise.
  assign space_o     = (count_q <= OFIFO_CNT_W'(OFIFO_DEPTH - 2));
  assign wr_ptr_nxt  = wr_ptr_q + OFIFO_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + OFIFO_PTR_W'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + OFIFO_PTR_W'(pop);
    count_d  = count_q + OFIFO_CNT_W'(push_i.cnt) - OFIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.res1;
    end
  end

endmodule

>>> rtl/core/eth_ipv4_tcp_header_parser.sv
// Top level of the Ethernet/IPv4/TCP header parser with payload text output.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   input    | in_valid_i, in_ready_o, in_data_i        | in
//   output   | out_valid_o, out_ready_i, out_data_o     | out
//   config   | cfg_we_i, cfg_wdata_i (http_port)        | in
//
// One frame byte is taken per cycle while in_ready_o is high; its results
// are written into a 4-entry result queue at the end of that cycle and leave
// at one per output transfer; in_ready_o drops with over two results queued.
// Reset puts the parser in idle (bytes ignored until a start of frame) and
// loads http_port with 80; no clearing pass is needed.
`include "assert_macros.svh"

module eth_ipv4_tcp_header_parser
  import eitp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic  in_fire;
  push_t push;

  assign in_fire = in_valid_i & in_ready_o;

  eitp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push)
  );

  eitp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `ASSERT_NEVER(a_push_needs_byte, clk_i, rst_ni, !in_fire && push.cnt != 2'd0)
  `ASSERT_PROP(a_pair_dot_first, clk_i, rst_ni, push.cnt == 2'd2 |-> push.res0.payload_char == CH_DOT)
  `ASSERT_PROP(a_stall_means_backlog, clk_i, rst_ni, !in_ready_o |-> out_valid_o)

endmodule
